### rtl/ite_pkg.sv
`timescale 1ns / 1ps
package ite_pkg;

    localparam int SPIN_W   = 1;
    localparam int CFG_W    = 7;
    localparam int ENERGY_W = 15;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = 15'h7fff;

    typedef logic [SPIN_W-1:0]   t_spin;
    typedef logic [CFG_W-1:0]    t_side_cfg;
    typedef logic [ENERGY_W-1:0] t_energy;

endpackage

### rtl/ite_spin_if.sv
`timescale 1ns / 1ps
interface ite_spin_if;
    logic           valid;
    logic           ready;
    ite_pkg::t_spin spin;

    modport source (output valid, output spin, input ready);
    modport sink   (input valid, input spin, output ready);
endinterface

### rtl/ite_cfg_if.sv
`timescale 1ns / 1ps
interface ite_cfg_if;
    logic               valid;
    logic               ready;
    ite_pkg::t_side_cfg lattice_side;

    modport source (output valid, output lattice_side, input ready);
    modport sink   (input valid, input lattice_side, output ready);
endinterface

### rtl/ite_energy_if.sv
`timescale 1ns / 1ps
interface ite_energy_if;
    logic             valid;
    logic             ready;
    ite_pkg::t_energy energy;

    modport source (output valid, output energy, input ready);
    modport sink   (input valid, input energy, output ready);
endinterface

### rtl/ite_ram.sv
`timescale 1ns / 1ps
module ite_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]                          o_rdata_a,
    output logic [WIDTH-1:0]                          o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### rtl/ite_fifo.sv
`timescale 1ns / 1ps
module ite_fifo #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [NW-1:0]    r_cnt;
    logic [NW-1:0]    n_cnt;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + NW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ptr_inc(r_wp);
            end
            if (i_pop) begin
                r_rp <= ptr_inc(r_rp);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    // no write into a full queue, no read from an empty one
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("queue underflow");

endmodule

### rtl/ite_front.sv
`timescale 1ns / 1ps
module ite_front #(
    parameter int MAX_SIDE = 64
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    ite_spin_if.sink                                        i_spin,
    ite_cfg_if.sink                                         i_cfg,
    output logic                                            o_push,
    output logic [((MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1) + 1:0] o_push_data,
    input  logic                                            i_full,
    output logic [$clog2(MAX_SIDE + 1)-1:0]                 o_side,
    output logic [$clog2(MAX_SIDE * MAX_SIDE + 1)-1:0]      o_cells
);
    import ite_pkg::*;

    localparam int SDW      = $clog2(MAX_SIDE + 1);
    localparam int AW       = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1;
    localparam int CNW      = $clog2(MAX_SIDE * MAX_SIDE + 1);
    localparam int RST_SIDE = (MAX_SIDE < 64) ? MAX_SIDE : 64;

    logic [SDW-1:0] r_side;
    logic [CNW-1:0] r_cells;
    logic [AW-1:0]  r_load;
    logic [SDW-1:0] n_side;
    logic           w_last;
    logic           w_xfer;
    logic           w_cfg;

    // zero means side one, anything above the maximum saturates
    always_comb begin
        if (i_cfg.lattice_side == '0) begin
            n_side = SDW'(1);
        end else if (int'(i_cfg.lattice_side) > MAX_SIDE) begin
            n_side = SDW'(MAX_SIDE);
        end else begin
            n_side = SDW'(i_cfg.lattice_side);
        end
    end

    assign w_cfg  = i_cfg.valid && i_cfg.ready;
    assign w_xfer = i_spin.valid && i_spin.ready;
    assign w_last = ((CNW'(r_load) + CNW'(1)) == r_cells);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side  <= SDW'(RST_SIDE);
            r_cells <= CNW'(RST_SIDE * RST_SIDE);
            r_load  <= '0;
        end else if (w_cfg) begin
            r_side  <= n_side;
            r_cells <= CNW'(n_side) * CNW'(n_side);
            r_load  <= '0;
        end else if (w_xfer) begin
            r_load <= w_last ? '0 : r_load + AW'(1);
        end
    end

    assign i_cfg.ready  = 1'b1;
    assign i_spin.ready = !i_full;
    assign o_push       = w_xfer;
    assign o_push_data  = {w_last, i_spin.spin, r_load};
    assign o_side       = r_side;
    assign o_cells      = r_cells;

    a_load_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNW'(r_load) < r_cells) else $error("load index beyond lattice");

endmodule

### rtl/ite_back.sv
`timescale 1ns / 1ps
module ite_back #(
    parameter int MAX_SIDE = 64
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_valid,
    input  logic [((MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1) + 1:0] i_data,
    output logic                                            o_pop,
    input  logic [$clog2(MAX_SIDE + 1)-1:0]                 i_side,
    input  logic [$clog2(MAX_SIDE * MAX_SIDE + 1)-1:0]      i_cells,
    ite_energy_if.source                                    o_energy
);
    import ite_pkg::*;

    localparam int SDW   = $clog2(MAX_SIDE + 1);
    localparam int CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int AW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1;
    localparam int CNW   = $clog2(MAX_SIDE * MAX_SIDE + 1);
    localparam int HW    = $clog2(2 * MAX_SIDE * MAX_SIDE + 1);
    localparam int EXT_W = (HW + 1 > ENERGY_W + 1) ? HW + 1 : ENERGY_W + 1;

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_EMIT  = 4'b1000
    } t_back_state;

    t_back_state      r_state;
    t_back_state      n_state;
    logic [AW-1:0]    r_a;
    logic [AW-1:0]    r_b;
    logic [CW-1:0]    r_col;
    logic [CW-1:0]    r_pcol;
    logic             r_pv;
    logic             r_prev;
    logic             r_first;
    logic [HW-1:0]    r_h;
    logic [HW-1:0]    n_h;
    logic             r_ov;
    t_energy          r_energy;

    logic             w_da;
    logic             w_db;
    logic [1:0]       w_inc;
    logic [CW-1:0]    w_col_last;
    logic             w_a_last;
    logic             w_emit;
    logic [EXT_W-1:0] w_dbl;
    t_energy          w_sat;

    ite_ram #(
        .WIDTH (1),
        .DEPTH (MAX_SIDE * MAX_SIDE)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (o_pop),
        .i_waddr   (i_data[AW-1:0]),
        .i_wdata   (i_data[AW]),
        .i_raddr_a (r_a),
        .i_raddr_b (r_b),
        .o_rdata_a (w_da),
        .o_rdata_b (w_db)
    );

    assign w_col_last = CW'(i_side - SDW'(1));
    assign w_a_last   = (CNW'(r_a) + CNW'(1) == i_cells);
    assign o_pop      = (r_state == S_LOAD) && i_valid;

    // down match, plus right match of the previous cell, plus row wrap match
    always_comb begin
        w_inc = {1'b0, (w_da == w_db)};
        if (r_pcol != '0) begin
            w_inc = w_inc + {1'b0, (w_da == r_prev)};
        end
        if (r_pcol == w_col_last) begin
            w_inc = w_inc + {1'b0, (r_pcol == '0) || (w_da == r_first)};
        end
    end

    assign n_h = r_pv ? r_h + HW'(w_inc) : r_h;

    // each down and right match stands for two of the four checks
    assign w_dbl = EXT_W'({r_h, 1'b0});
    assign w_sat = (w_dbl > EXT_W'(ENERGY_MAX)) ? ENERGY_MAX : w_dbl[ENERGY_W-1:0];

    assign w_emit = (r_state == S_EMIT) && (!r_ov || o_energy.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (i_valid && i_data[AW+1]) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_a_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_EMIT;
            S_EMIT: begin
                if (w_emit) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= (r_state == S_SCAN);
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (o_energy.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) begin
            r_a   <= '0;
            r_b   <= (i_side == SDW'(1)) ? '0 : AW'(i_side);
            r_col <= '0;
            r_h   <= '0;
        end else begin
            if (r_state == S_SCAN) begin
                r_a   <= r_a + AW'(1);
                r_b   <= (CNW'(r_b) + CNW'(1) == i_cells) ? '0 : r_b + AW'(1);
                r_col <= (r_col == w_col_last) ? '0 : r_col + CW'(1);
            end
            r_h <= n_h;
        end
        r_pcol <= r_col;
        if (r_pv) begin
            r_prev <= w_da;
            if (r_pcol == '0) begin
                r_first <= w_da;
            end
        end
        if (w_emit) begin
            r_energy <= w_sat;
        end
    end

    assign o_energy.valid  = r_ov;
    assign o_energy.energy = r_energy;

    a_no_pop_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> !o_pop) else $error("queue read during scan");
    a_b_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CNW'(r_b) < i_cells)) else $error("down address out of range");
    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == S_EMIT)) else $error("result without scan");

endmodule

### rtl/ising_torus_energy.sv
`timescale 1ns / 1ps
// channel    dir  payload              transfer
// i_spin     in   spin [0:0]           valid && ready
// i_cfg      in   lattice_side [6:0]   valid && ready, always ready
// o_energy   out  energy [14:0]        valid && ready
//
// each spin goes through a two-entry queue and is written to the spin ram
// the last spin starts the scan, then the drain and emit states pass the result to the output register
// two read ports give each cell and the cell below it
// reset clears control only, the spin ram has no clearing pass
// the result waits in an output register, loading of the next lattice goes on meanwhile
// the queue fills and i_spin.ready drops while a scan runs or a result is stalled
module ising_torus_energy #(
    parameter int MAX_SIDE = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ite_spin_if.sink     i_spin,
    ite_cfg_if.sink      i_cfg,
    ite_energy_if.source o_energy
);
    import ite_pkg::*;

    localparam int SDW = $clog2(MAX_SIDE + 1);
    localparam int AW  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1;
    localparam int CNW = $clog2(MAX_SIDE * MAX_SIDE + 1);
    localparam int QW  = AW + 2;

    logic           w_push;
    logic [QW-1:0]  w_push_data;
    logic           w_full;
    logic           w_pop;
    logic           w_qvalid;
    logic [QW-1:0]  w_qdata;
    logic [SDW-1:0] w_side;
    logic [CNW-1:0] w_cells;

    ite_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_spin      (i_spin),
        .i_cfg       (i_cfg),
        .o_push      (w_push),
        .o_push_data (w_push_data),
        .i_full      (w_full),
        .o_side      (w_side),
        .o_cells     (w_cells)
    );

    ite_fifo #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_data  (w_qdata)
    );

    ite_back #(
        .MAX_SIDE (MAX_SIDE)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_qvalid),
        .i_data   (w_qdata),
        .o_pop    (w_pop),
        .i_side   (w_side),
        .i_cells  (w_cells),
        .o_energy (o_energy)
    );

endmodule

### test/tb_ising_torus_energy.sv
`timescale 1ns / 1ps
module tb_ising_torus_energy;
    import ite_pkg::*;

    localparam int        MAX_SIDE     = 64;
    localparam int        CELLS        = MAX_SIDE * MAX_SIDE;
    localparam int        CLK_HALF     = 10;
    localparam int        CYCLE_LIMIT  = 1000000;
    localparam int        HOLD_CYCLES  = 300;
    localparam int        IDLE_PCT     = 21;
    localparam int        RANDOM_ITEMS = 1600;
    localparam int        CALM_ITEMS   = 400;
    localparam int        TAIL_CYCLES  = CELLS + 16;
    localparam int        MAX_REPORTS  = 10;
    localparam t_side_cfg RESET_SIDE   = 7'd64;

    typedef enum int {
        PAT_RANDOM,
        PAT_ZEROS,
        PAT_ONES,
        PAT_CHECKER,
        PAT_STRIPES,
        PAT_SPARSE
    } t_pattern;

    logic i_clk;
    logic i_rst_n;

    ite_spin_if   spin_bus ();
    ite_cfg_if    cfg_bus ();
    ite_energy_if energy_bus ();

    ising_torus_energy #(
        .MAX_SIDE(MAX_SIDE)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_spin  (spin_bus),
        .i_cfg   (cfg_bus),
        .o_energy(energy_bus)
    );

    // lattice model state
    t_spin     lattice_bits [CELLS];
    int        loaded_spins = 0;
    t_side_cfg side_reg     = RESET_SIDE;
    t_energy   expected_energy [$];

    int err_count   = 0;
    int spins_sent  = 0;
    int hold_reqs   = 0;
    int cycle_count = 0;
    int tx_idle_pct = IDLE_PCT;
    int rx_idle_pct = IDLE_PCT;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic int active_side(input t_side_cfg v);
        if (v == 0) return 1;
        if (v > MAX_SIDE) return MAX_SIDE;
        return int'(v);
    endfunction

    function automatic t_energy torus_energy(input int s);
        int    total;
        t_spin me;
        total = 0;
        for (int r = 0; r < s; r++) begin
            for (int c = 0; c < s; c++) begin
                me = lattice_bits[r * s + c];
                if (lattice_bits[((r + s - 1) % s) * s + c] == me) total++;
                if (lattice_bits[((r + 1) % s) * s + c] == me) total++;
                if (lattice_bits[r * s + (c + s - 1) % s] == me) total++;
                if (lattice_bits[r * s + (c + 1) % s] == me) total++;
            end
        end
        if (total > int'(ENERGY_MAX)) total = int'(ENERGY_MAX);
        return t_energy'(total);
    endfunction

    function automatic void record_spin(input t_spin s);
        int side;
        side = active_side(side_reg);
        lattice_bits[loaded_spins] = s;
        loaded_spins++;
        if (loaded_spins >= side * side) begin
            loaded_spins = 0;
            expected_energy.push_back(torus_energy(side));
        end
    endfunction

    function automatic t_spin pattern_spin(input t_pattern pat, input int idx, input int s);
        case (pat)
            PAT_ZEROS:   return 1'b0;
            PAT_ONES:    return 1'b1;
            PAT_CHECKER: return t_spin'(((idx / s) + (idx % s)) % 2);
            PAT_STRIPES: return t_spin'((idx / s) % 2);
            PAT_SPARSE:  return t_spin'($urandom_range(7) == 0);
            default:     return t_spin'($urandom_range(1));
        endcase
    endfunction

    function automatic void note_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) $display("cycle %0d: %s", cycle_count, msg);
    endfunction

    task automatic send_spin(input t_spin s);
        while ($urandom_range(99) < tx_idle_pct) begin
            spin_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        spin_bus.valid <= 1'b1;
        spin_bus.spin  <= s;
        do @(posedge i_clk); while (!spin_bus.ready);
        spins_sent++;
        record_spin(s);
    endtask

    task automatic send_lattice(input t_pattern pat);
        int s;
        s = active_side(side_reg);
        for (int i = 0; i < s * s; i++) send_spin(pattern_spin(pat, i, s));
    endtask

    // only while idle: all energies back, then let a partial load settle
    task automatic write_side(input t_side_cfg v);
        int s;
        s = active_side(side_reg);
        spin_bus.valid <= 1'b0;
        while (expected_energy.size() != 0) @(posedge i_clk);
        repeat (s * s + 16) @(posedge i_clk);
        cfg_bus.valid        <= 1'b1;
        cfg_bus.lattice_side <= v;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        side_reg     = v;
        loaded_spins = 0;
    endtask

    // first row at the reset side, dropped by the next side write
    task automatic test_reset_side();
        for (int i = 0; i < MAX_SIDE; i++) send_spin(pattern_spin(PAT_RANDOM, i, MAX_SIDE));
    endtask

    task automatic test_small_sides();
        // side zero behaves as side one
        write_side(7'd0);
        send_spin(1'b0);
        send_spin(1'b1);
        write_side(7'd1);
        send_spin(1'b1);
        // side two counts the same neighbour twice
        write_side(7'd2);
        send_lattice(PAT_CHECKER);
        send_lattice(PAT_ONES);
        write_side(7'd3);
        send_lattice(PAT_STRIPES);
    endtask

    task automatic test_load_restart();
        write_side(7'd4);
        repeat (7) send_spin(t_spin'($urandom_range(1)));
        write_side(7'd4);
        send_lattice(PAT_RANDOM);
        write_side(7'd3);
        repeat (5) send_spin(1'b1);
        write_side(7'd2);
        send_lattice(PAT_ZEROS);
    endtask

    // partial loads only, no result may appear
    task automatic test_side_saturation();
        write_side(7'd64);
        repeat (10) send_spin(1'b1);
        write_side(7'd127);
        for (int i = 0; i < 70; i++) send_spin(pattern_spin(PAT_CHECKER, i, MAX_SIDE));
    endtask

    task automatic test_output_stall();
        write_side(7'd2);
        tx_idle_pct = 0;
        hold_reqs++;
        repeat (25) send_lattice(PAT_RANDOM);
        tx_idle_pct = IDLE_PCT;
    endtask

    task automatic test_random_lattices();
        int       start_count;
        int       s_val;
        int       s;
        int       p;
        t_pattern pat;
        start_count = spins_sent;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        while (spins_sent - start_count < RANDOM_ITEMS) begin
            if (spins_sent - start_count >= CALM_ITEMS) begin
                tx_idle_pct = IDLE_PCT;
                rx_idle_pct = IDLE_PCT;
            end
            case ($urandom_range(19))
                0:       s_val = 0;
                1, 2:    s_val = $urandom_range(9, 16);
                default: s_val = $urandom_range(1, 8);
            endcase
            write_side(t_side_cfg'(s_val));
            s = active_side(side_reg);
            repeat ($urandom_range(1, 6)) begin
                p   = $urandom_range(9);
                pat = (p > int'(PAT_SPARSE)) ? PAT_RANDOM : t_pattern'(p);
                send_lattice(pat);
            end
            // partial lattice, dropped by the next side write
            if (s > 1 && $urandom_range(4) == 0) begin
                repeat ($urandom_range(1, s * s - 1)) send_spin(t_spin'($urandom_range(1)));
            end
        end
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
    endtask

    initial begin : result_sink
        int      stall_left;
        int      hold_seen;
        t_energy want;
        stall_left = 0;
        hold_seen  = 0;
        energy_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && energy_bus.valid && energy_bus.ready) begin
                if (expected_energy.size() == 0) begin
                    note_error($sformatf("energy %0d transferred with none expected",
                                         energy_bus.energy));
                end else begin
                    want = expected_energy.pop_front();
                    if (energy_bus.energy !== want) begin
                        note_error($sformatf("energy expected %0d, actual %0d",
                                             want, energy_bus.energy));
                    end
                end
            end
            if (hold_reqs != hold_seen) begin
                hold_seen  = hold_reqs;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                energy_bus.ready <= 1'b0;
            end else begin
                energy_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        i_rst_n              <= 1'b0;
        spin_bus.valid       <= 1'b0;
        spin_bus.spin        <= '0;
        cfg_bus.valid        <= 1'b0;
        cfg_bus.lattice_side <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_side();
        test_small_sides();
        test_load_restart();
        test_side_saturation();
        test_output_stall();
        test_random_lattices();

        spin_bus.valid <= 1'b0;
        while (expected_energy.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
